>>> rtl/dstq_pkg.sv
// Shared types, widths and codes for the deadline-sorted timer queue.
package dstq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_FIRE        = 16;
	localparam int TIME_W          = 32;
	localparam int TOKEN_W         = 32;
	localparam int HANDLE_W        = 16;
	localparam int DELAY_W         = 31;
	localparam int WINDOW_W        = 8;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd1;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_FIRE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_ANS
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]   deadline;
		logic [TOKEN_W-1:0]  token;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

endpackage

>>> rtl/dstq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module dstq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/deadline_sorted_timer_queue_core.sv
// Deadline-sorted timer queue: sequencer, entry store and output register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_ready  | action, delay, job_handle, token
//   output   | out_valid / out_ready| kind, token_res, job_handle_res, ok, last
//   config   | cfg_we               | cfg_wdata (early window)
//
// One transaction at a time; in_ready is high only while the sequencer idles.
// Add, remove and tick walk the stored entries through the single RAM read
// port, one SCAN state and one EVAL state per entry.
// Clear and an add to a full queue go straight to the answer state, where
// they wait for the output handshake.
// A stalled output holds the walk at the next fired entry; input waits.
// Reset clears count and time and sets the token counter to one at once; no clearing pass.
module deadline_sorted_timer_queue_core #(
	parameter int QUEUE_DEPTH = dstq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [dstq_pkg::DELAY_W-1:0]  delay,
	input  logic [dstq_pkg::HANDLE_W-1:0] job_handle,
	input  logic [dstq_pkg::TOKEN_W-1:0]  token,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [dstq_pkg::TOKEN_W-1:0]  token_res,
	output logic [dstq_pkg::HANDLE_W-1:0] job_handle_res,
	output logic                          ok,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [dstq_pkg::WINDOW_W-1:0] cfg_wdata
);

	import dstq_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FW = $clog2(MAX_FIRE + 1);
	localparam int EW = $bits(entry_t);
	localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
	localparam logic [FW-1:0] MAX_FIRE_C = FW'(MAX_FIRE);

	state_t               state_q, state_d;
	action_t              op_q;
	logic [CW-1:0]        cnt_q, r_q, w_q;
	logic [TIME_W-1:0]    time_q;
	logic [TOKEN_W-1:0]   next_tok_q, rm_tok_q;
	logic [WINDOW_W-1:0]  win_q;
	entry_t               hold_q;
	logic                 ins_q, ok_q;
	logic [FW-1:0]        fire_n_q;
	logic                 pend_v_q;
	logic [TOKEN_W-1:0]   pend_tok_q;
	logic [HANDLE_W-1:0]  pend_hnd_q;

	logic                 out_valid_q;
	kind_t                kind_q;
	logic [TOKEN_W-1:0]   token_res_q;
	logic [HANDLE_W-1:0]  job_handle_res_q;
	logic                 ok_out_q, last_q;

	logic                 in_acc, out_free, scan_end;
	logic                 later, match, due, fire, stall;
	logic [TIME_W-1:0]    cmp_a, cmp_b, diff;
	logic [TOKEN_W-1:0]   tok_inc;
	entry_t               rd_e, ram_wdata;
	logic [EW-1:0]        ram_rdata;
	logic                 ram_we, ram_re;
	logic [IW-1:0]        ram_waddr, ram_raddr;
	logic                 emit, e_ok, e_last;
	kind_t                e_kind;
	logic [TOKEN_W-1:0]   e_tok;
	logic [HANDLE_W-1:0]  e_hnd;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign out_free = !out_valid_q | out_ready;
	assign scan_end = (r_q == cnt_q);
	assign rd_e     = entry_t'(ram_rdata);
	assign tok_inc  = next_tok_q + TOKEN_W'(1);

	// shared compare unit: one subtract per visited entry
	// add: new deadline minus stored one; tick: stored deadline minus now
	assign cmp_a = (op_q == ACT_ADD) ? hold_q.deadline : rd_e.deadline;
	assign cmp_b = (op_q == ACT_ADD) ? rd_e.deadline : time_q;
	assign diff  = cmp_a - cmp_b;
	assign later = diff[TIME_W-1];
	assign due   = diff[TIME_W-1] | (diff < TIME_W'(win_q));
	assign match = (rd_e.token == rm_tok_q);
	assign fire  = due && (fire_n_q < MAX_FIRE_C);
	assign stall = (state_q == ST_EVAL) && (op_q == ACT_TICK) && fire && pend_v_q
		&& !out_free;

	// entry store
	dstq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (action_t'(action))
						ACT_ADD:   state_d = (cnt_q >= DEPTH_C) ? ST_ANS : ST_SCAN;
						ACT_CLEAR: state_d = ST_ANS;
						default:   state_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = (op_q == ACT_TICK && !pend_v_q) ? ST_IDLE : ST_ANS;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!stall) begin
					state_d = ST_SCAN;
				end
			end
			ST_ANS: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM control and result emission
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = r_q[IW-1:0];
		ram_wdata = hold_q;
		ram_re    = 1'b0;
		ram_raddr = r_q[IW-1:0];
		emit      = 1'b0;
		e_kind    = KIND_FIRE;
		e_tok     = '0;
		e_hnd     = '0;
		e_ok      = 1'b0;
		e_last    = 1'b1;
		case (state_q)
			ST_SCAN: begin
				if (scan_end) begin
					// add: the new or last displaced entry goes to the tail
					ram_we = (op_q == ACT_ADD);
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_EVAL: begin
				case (op_q)
					ACT_ADD: begin
						ram_we = ins_q | later;
					end
					ACT_REMOVE: begin
						ram_we    = !match;
						ram_waddr = w_q[IW-1:0];
						ram_wdata = rd_e;
					end
					ACT_TICK: begin
						if (fire) begin
							// previous fired entry is now known not to be last
							emit   = pend_v_q & out_free;
							e_tok  = pend_tok_q;
							e_hnd  = pend_hnd_q;
							e_ok   = 1'b1;
							e_last = 1'b0;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = w_q[IW-1:0];
							ram_wdata = rd_e;
						end
					end
					default: ;
				endcase
			end
			ST_ANS: begin
				emit = out_free;
				e_ok = ok_q;
				case (op_q)
					ACT_ADD: begin
						e_kind = KIND_ADD;
						e_tok  = ok_q ? next_tok_q : '0;
					end
					ACT_REMOVE: e_kind = KIND_REMOVE;
					ACT_CLEAR:  e_kind = KIND_CLEAR;
					default: begin
						e_kind = KIND_FIRE;
						e_tok  = pend_tok_q;
						e_hnd  = pend_hnd_q;
						e_ok   = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			r_q         <= '0;
			w_q         <= '0;
			time_q      <= '0;
			next_tok_q  <= TOKEN_W'(1);
			win_q       <= WINDOW_RESET;
			ins_q       <= 1'b0;
			fire_n_q    <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						r_q      <= '0;
						w_q      <= '0;
						ins_q    <= 1'b0;
						fire_n_q <= '0;
						pend_v_q <= 1'b0;
						if (action_t'(action) == ACT_CLEAR) begin
							cnt_q <= '0;
						end
						if (action_t'(action) == ACT_TICK) begin
							time_q <= time_q + TIME_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						if (op_q == ACT_ADD) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							cnt_q <= w_q;
						end
					end
				end
				ST_EVAL: begin
					if (!stall) begin
						r_q <= r_q + CW'(1);
						case (op_q)
							ACT_ADD: begin
								if (later) begin
									ins_q <= 1'b1;
								end
							end
							ACT_REMOVE: begin
								if (!match) begin
									w_q <= w_q + CW'(1);
								end
							end
							ACT_TICK: begin
								if (fire) begin
									pend_v_q <= 1'b1;
									fire_n_q <= fire_n_q + FW'(1);
								end else begin
									w_q <= w_q + CW'(1);
								end
							end
							default: ;
						endcase
					end
				end
				ST_ANS: begin
					// token counter skips zero on wrap
					if (out_free && op_q == ACT_ADD && ok_q) begin
						next_tok_q <= (tok_inc == '0) ? TOKEN_W'(1) : tok_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q            <= action_t'(action);
					rm_tok_q        <= token;
					hold_q.deadline <= time_q + TIME_W'(delay);
					hold_q.token    <= next_tok_q;
					hold_q.handle   <= job_handle;
					case (action_t'(action))
						ACT_ADD:   ok_q <= (cnt_q < DEPTH_C);
						ACT_CLEAR: ok_q <= (cnt_q != '0);
						default:   ok_q <= 1'b0;
					endcase
				end
			end
			ST_EVAL: begin
				if (!stall) begin
					case (op_q)
						ACT_ADD: begin
							if (ins_q | later) begin
								hold_q <= rd_e;
							end
						end
						ACT_REMOVE: begin
							if (match) begin
								ok_q <= 1'b1;
							end
						end
						ACT_TICK: begin
							if (fire) begin
								pend_tok_q <= rd_e.token;
								pend_hnd_q <= rd_e.handle;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		if (emit) begin
			kind_q           <= e_kind;
			token_res_q      <= e_tok;
			job_handle_res_q <= e_hnd;
			ok_out_q         <= e_ok;
			last_q           <= e_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign token_res      = token_res_q;
	assign job_handle_res = job_handle_res_q;
	assign ok             = ok_out_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count exceeds queue depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= cnt_q))
		else $error("entry write beyond queue tail");

	a_eval_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (r_q < cnt_q))
		else $error("entry visited beyond queue tail");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= r_q)
		else $error("compaction write pointer ahead of read pointer");

	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ANS && op_q == ACT_TICK) |-> pend_v_q)
		else $error("final fire transaction without a pending entry");
`endif

endmodule
